FILE: rtl/core/mkpm_pkg.sv
// Shared types and constants for the multi-keyword prefix matcher.
// No dependencies; imported by multi_keyword_prefix_matcher_top.
`timescale 1ns / 1ps

package mkpm_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_FEED    = 2'd1,
        ACT_WR_BYTE = 2'd2,
        ACT_WR_LEN  = 2'd3
    } t_action;

    localparam int DEF_NUM_PATTERNS = 16;
    localparam int DEF_MAX_LEN      = 32;

    localparam int CH_W      = 8;
    localparam int IDX_FLD_W = 4;
    localparam int CPOS_FLD_W = 5;
    localparam int LEN_FLD_W = 6;
    localparam int SEEN_W    = 6;
    localparam int CFG_W     = 5;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

FILE: rtl/core/multi_keyword_prefix_matcher_top.sv
// Multi-keyword prefix matcher: input register, byte-row memory, parallel compare.
// Depends on mkpm_pkg.
//
//  channel   dir  handshake              payload
//  s (item)  in   i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (action)
//  m (res)   out  o_m_tvalid/i_m_tready  o_m_tdata
//  cfg       in   i_cfg_we               i_cfg_wdata (patterns_in_use)
//
// One beat per cycle unless the output stalls; each result passes the input register
// and then the output register. The rate is set by the compare of all active patterns
// against one memory row (one row per stream position, one byte lane per pattern).
// Synchronous active-low reset clears flags, position, valids, sets cfg to CFG_RESET;
// tables are kept. A stalled output holds the input register; o_s_tready then drops.
`timescale 1ns / 1ps

module multi_keyword_prefix_matcher_top
    import mkpm_pkg::*;
#(
    parameter int NUM_PATTERNS = DEF_NUM_PATTERNS,
    parameter int MAX_LEN      = DEF_MAX_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // ch[7:0], pattern_index[11:8], char_position[16:12], pattern_length[22:17]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // match_found[0], match_index[4:1], any_survivor[5], chars_seen[11:6]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int PI_W   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int POS_W  = $clog2(MAX_LEN + 2);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ROW_W  = NUM_PATTERNS * CH_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN + 1);

    t_action                  in_act;
    logic [CH_W-1:0]          in_ch;
    logic [IDX_FLD_W-1:0]     in_idx;
    logic [CPOS_FLD_W-1:0]    in_cpos;
    logic [LEN_FLD_W-1:0]     in_len;
    logic                     accept;
    logic                     s1_go;
    logic                     idx_ok;
    logic                     cpos_ok;
    logic [PI_W-1:0]          wr_lane;
    logic [ADDR_W-1:0]        wr_addr;
    logic [LEN_W-1:0]         len_clamp;
    logic [POS_W-1:0]         rd_pos;
    logic [ADDR_W-1:0]        rd_addr;

    logic                     r_s1_valid;
    t_action                  r_s1_act;
    logic [CH_W-1:0]          r_s1_ch;
    logic [ROW_W-1:0]         r_row;
    logic                     r_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic [CFG_W-1:0]         r_cfg;
    logic [NUM_PATTERNS-1:0]  r_ruled;
    logic [POS_W-1:0]         r_pos;
    logic [LEN_W-1:0]         r_len [NUM_PATTERNS];
    logic [ROW_W-1:0]         r_mem [MAX_LEN];

    logic [NUM_PATTERNS-1:0]  active;
    logic [NUM_PATTERNS-1:0]  n_ruled;
    logic [POS_W-1:0]         n_pos;
    logic                     found;
    logic                     any;
    logic [PI_W-1:0]          surv;

    assign in_act  = t_action'(i_s_tuser);
    assign in_ch   = i_s_tdata[7:0];
    assign in_idx  = i_s_tdata[11:8];
    assign in_cpos = i_s_tdata[16:12];
    assign in_len  = i_s_tdata[22:17];

    assign s1_go      = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_go;
    assign accept     = i_s_tvalid && o_s_tready;

    assign idx_ok    = 32'(in_idx) < NUM_PATTERNS;
    assign cpos_ok   = 32'(in_cpos) < MAX_LEN;
    assign wr_lane   = PI_W'(in_idx);
    assign wr_addr   = ADDR_W'(in_cpos);
    assign len_clamp = (32'(in_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(in_len);

    // position the newly accepted beat will see
    assign rd_pos  = r_s1_valid ? n_pos : r_pos;
    assign rd_addr = (32'(rd_pos) < MAX_LEN) ? ADDR_W'(rd_pos) : '0;

    always_comb begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            active[p] = 32'(p) < 32'(r_cfg);
        end
    end

    always_comb begin
        n_ruled = r_ruled;
        n_pos   = r_pos;
        case (r_s1_act)
            ACT_CLEAR: begin
                n_ruled = '0;
                n_pos   = '0;
            end
            ACT_FEED: begin
                for (int p = 0; p < NUM_PATTERNS; p++) begin
                    if (active[p] && !r_ruled[p]) begin
                        if (r_pos < POS_W'(r_len[p])) begin
                            n_ruled[p] = r_row[p*CH_W +: CH_W] != r_s1_ch;
                        end else if (r_pos == POS_W'(r_len[p])) begin
                            n_ruled[p] = r_s1_ch != '0;
                        end else begin
                            n_ruled[p] = 1'b1;
                        end
                    end
                end
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // lowest-indexed survivor
    always_comb begin
        found = 1'b0;
        any   = 1'b0;
        surv  = '0;
        for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
            if (active[p] && !n_ruled[p]) begin
                any   = 1'b1;
                surv  = PI_W'(p);
                found = POS_W'(r_len[p]) == n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ruled     <= '0;
            r_pos       <= '0;
            r_cfg       <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_ruled     <= n_ruled;
                r_pos       <= n_pos;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_act <= in_act;
            r_s1_ch  <= in_ch;
        end
        if (s1_go) begin
            r_out_data <= {4'b0, SEEN_W'(n_pos), any, 4'(surv), found};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_act == ACT_WR_LEN && idx_ok) begin
            r_len[wr_lane] <= len_clamp;
        end
    end

    // one row per stream position, one byte lane per pattern
    always_ff @(posedge i_clk) begin
        if (accept && in_act == ACT_WR_BYTE && idx_ok && cpos_ok) begin
            r_mem[wr_addr][wr_lane*CH_W +: CH_W] <= in_ch;
        end
        if (accept) begin
            r_row <= r_mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("stream position past saturation");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_act == ACT_CLEAR |=> r_pos == '0 && r_ruled == '0)
        else $error("clear did not reset flags and position");

    a_feed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_act == ACT_FEED && r_pos < POS_MAX
        |=> r_pos == POS_W'($past(r_pos) + 1'b1))
        else $error("feed did not advance position");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> $stable(r_pos) && $stable(r_ruled))
        else $error("match state changed during output stall");

    a_no_survivor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[5] |-> r_out_data[4:0] == '0)
        else $error("match reported without a survivor");
`endif

endmodule

FILE: tb/sv/multi_keyword_prefix_matcher_top_tb.sv
// Self-checking testbench for multi_keyword_prefix_matcher_top: keyword loads, match streams,
// several keyword-count settings, bursty sender, stalling receiver, in-line status predictor.
// Depends on mkpm_pkg and multi_keyword_prefix_matcher_top.
`timescale 1ns / 1ps

module multi_keyword_prefix_matcher_top_tb;
    import mkpm_pkg::*;

    localparam int NUM_KW = DEF_NUM_PATTERNS;
    localparam int KW_MAX = DEF_MAX_LEN;

    typedef struct packed {
        t_action                action;
        logic [CH_W-1:0]        ch;
        logic [IDX_FLD_W-1:0]   idx;
        logic [CPOS_FLD_W-1:0]  cpos;
        logic [LEN_FLD_W-1:0]   len;
    } t_matcher_cmd;

    // first member lands in the top bits: seen[11:6], any[5], index[4:1], found[0]
    typedef struct packed {
        logic [SEEN_W-1:0]      seen;
        logic                   any;
        logic [IDX_FLD_W-1:0]   index;
        logic                   found;
    } t_matcher_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    multi_keyword_prefix_matcher_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [CH_W-1:0] kw_bytes [NUM_KW][KW_MAX];
    int              kw_len   [NUM_KW];
    bit              kw_dead  [NUM_KW];
    int              seen_pos = 0;
    int              kw_in_use = int'(CFG_RESET);

    // generator bookkeeping, in queue order
    logic [CH_W-1:0] gen_bytes [NUM_KW][KW_MAX];
    bit              gen_wr    [NUM_KW][KW_MAX];
    int              gen_len   [NUM_KW];
    int              gen_count = 0;

    t_matcher_cmd    cmd_queue[$];
    t_matcher_status status_due[$];
    int              mismatches = 0;

    function automatic t_matcher_status advance_matcher(t_matcher_cmd cmd);
        t_matcher_status st;
        int  n;
        bit  same;
        bit  hit;
        n = (kw_in_use > NUM_KW) ? NUM_KW : kw_in_use;
        case (cmd.action)
            ACT_CLEAR: begin
                kw_dead = '{default: 1'b0};
                seen_pos = 0;
            end
            ACT_FEED: begin
                for (int p = 0; p < n; p++) begin
                    if (!kw_dead[p]) begin
                        if (seen_pos < kw_len[p]) same = (kw_bytes[p][seen_pos] == cmd.ch);
                        else if (seen_pos == kw_len[p]) same = (cmd.ch == '0);
                        else same = 1'b0;
                        kw_dead[p] = !same;
                    end
                end
                if (seen_pos < KW_MAX + 1) seen_pos++;
            end
            ACT_WR_BYTE: begin
                kw_bytes[cmd.idx][cmd.cpos] = cmd.ch;
            end
            default: begin
                kw_len[cmd.idx] = (cmd.len > KW_MAX) ? KW_MAX : int'(cmd.len);
            end
        endcase
        st = '0;
        hit = 1'b0;
        for (int p = 0; p < n; p++) begin
            if (!hit && !kw_dead[p]) begin
                hit = 1'b1;
                st.any = 1'b1;
                st.index = p[IDX_FLD_W-1:0];
                st.found = (kw_len[p] == seen_pos);
            end
        end
        st.seen = seen_pos[SEEN_W-1:0];
        return st;
    endfunction

    task automatic add_item(input t_action a, input int ch, input int idx, input int cpos,
                            input int len);
        t_matcher_cmd cmd;
        cmd.action = a;
        cmd.ch = ch[CH_W-1:0];
        cmd.idx = idx[IDX_FLD_W-1:0];
        cmd.cpos = cpos[CPOS_FLD_W-1:0];
        cmd.len = len[LEN_FLD_W-1:0];
        cmd_queue.push_back(cmd);
        gen_count++;
        if (a == ACT_WR_BYTE) begin
            gen_bytes[idx][cpos] = cmd.ch;
            gen_wr[idx][cpos] = 1'b1;
        end else if (a == ACT_WR_LEN) begin
            gen_len[idx] = (len > KW_MAX) ? KW_MAX : len;
        end
    endtask

    task automatic wait_all_results();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_s_tvalid || status_due.size() != 0);
    endtask

    task automatic write_in_use(input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        kw_in_use = v;
    endtask

    // sender: bursts with gaps, occasional pause until all results are back
    t_matcher_cmd cur_cmd;
    int           burst_left = 0;
    int           gap_left = 0;
    bit           drain_hold = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                status_due.push_back(advance_matcher(cur_cmd));
                if ($urandom_range(0, 199) == 0) drain_hold = 1'b1;
            end
            if (drain_hold && status_due.size() == 0) drain_hold = 1'b0;
            if (i_s_tvalid && !o_s_tready) begin
                // hold the current beat
            end else if (gap_left > 0 || drain_hold) begin
                if (gap_left > 0) gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cur_cmd = cmd_queue.pop_front();
                i_s_tdata <= {1'b0, cur_cmd.len, cur_cmd.cpos, cur_cmd.idx, cur_cmd.ch};
                i_s_tuser <= cur_cmd.action;
                i_s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating ready pattern, two long hold-offs
    logic [15:0]     rdy_pat = 16'hFFFF;
    int              pat_age = 0;
    int              hold_left = 0;
    int              results_seen = 0;
    t_matcher_status want;
    t_matcher_status got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                got = o_m_tdata[11:0];
                if (status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                end else begin
                    want = status_due.pop_front();
                    if (got.found !== want.found) begin
                        mismatches++;
                        $display("%0t: match_found expected %0d actual %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.index !== want.index) begin
                        mismatches++;
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.index, got.index);
                    end
                    if (got.any !== want.any) begin
                        mismatches++;
                        $display("%0t: any_survivor expected %0d actual %0d",
                                 $time, want.any, got.any);
                    end
                    if (got.seen !== want.seen) begin
                        mismatches++;
                        $display("%0t: chars_seen expected %0d actual %0d",
                                 $time, want.seen, got.seen);
                    end
                end
                if (results_seen == 150 || results_seen == 700) hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (pat_age == 0) begin
                    case ($urandom_range(0, 3))
                        0: rdy_pat = 16'hFFFF;
                        1: rdy_pat = $urandom;
                        2: rdy_pat = $urandom | $urandom;
                        default: rdy_pat = 16'h0F0F;
                    endcase
                    if (rdy_pat == '0) rdy_pat = 16'h8001;
                    pat_age = $urandom_range(16, 96);
                end else begin
                    pat_age--;
                end
                i_m_tready <= rdy_pat[0];
                rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
            end
        end
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int plan [8];
        int phase_end;
        int idx;
        int src;
        int l;
        int n;
        int c;
        t_action a;

        plan = '{16, 1, 16, 7, 0, 31, 3, 16};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every length known before the first feed; keyword 1 is "ab"
        for (int k = 0; k < NUM_KW; k++) add_item(ACT_WR_LEN, 0, k, 0, 0);
        add_item(ACT_WR_BYTE, 8'h61, 1, 0, 0);
        add_item(ACT_WR_BYTE, 8'h62, 1, 1, 0);
        add_item(ACT_WR_LEN, 0, 1, 0, 2);
        add_item(ACT_CLEAR, 0, 0, 0, 0);
        add_item(ACT_FEED, 8'h61, 0, 0, 0);
        add_item(ACT_FEED, 8'h62, 0, 0, 0);
        add_item(ACT_FEED, 8'h00, 0, 0, 0);
        add_item(ACT_FEED, 8'hFF, 15, 31, 32);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_all_results();
                repeat (8) @(posedge i_clk);
                write_in_use(plan[ph]);
            end
            phase_end = gen_count + 180;
            while (gen_count < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        // load a keyword, often sharing a prefix with another one
                        idx = $urandom_range(0, NUM_KW - 1);
                        src = $urandom_range(0, NUM_KW - 1);
                        l = ($urandom_range(0, 9) == 0) ? $urandom_range(9, KW_MAX)
                                                        : $urandom_range(1, 8);
                        for (int i = 0; i < l; i++) begin
                            if ($urandom_range(0, 2) != 0 && i < gen_len[src])
                                c = gen_bytes[src][i];
                            else if ($urandom_range(0, 3) == 0)
                                c = $urandom_range(0, 255);
                            else
                                c = 8'h61 + $urandom_range(0, 3);
                            add_item(ACT_WR_BYTE, c, idx, i, $urandom_range(0, 32));
                        end
                        if (l == KW_MAX && $urandom_range(0, 1) == 0) l = $urandom_range(33, 63);
                        add_item(ACT_WR_LEN, $urandom_range(0, 255), idx,
                                 $urandom_range(0, 31), l);
                    end
                    5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: begin
                        // stream one keyword, sometimes corrupted, then an optional tail
                        idx = $urandom_range(0, NUM_KW - 1);
                        if ($urandom_range(0, 4) != 0)
                            add_item(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 15),
                                     $urandom_range(0, 31), $urandom_range(0, 32));
                        for (int i = 0; i < gen_len[idx]; i++) begin
                            c = gen_bytes[idx][i];
                            if ($urandom_range(0, 15) == 0) c = $urandom_range(0, 255);
                            add_item(ACT_FEED, c, $urandom_range(0, 15),
                                     $urandom_range(0, 31), $urandom_range(0, 32));
                        end
                        case ($urandom_range(0, 2))
                            0: add_item(ACT_FEED, 0, 0, 0, 0);
                            1: begin
                                n = $urandom_range(1, 3);
                                for (int i = 0; i < n; i++)
                                    add_item(ACT_FEED, 8'h61 + $urandom_range(0, 3), 0, 0, 0);
                            end
                            default: ;
                        endcase
                    end
                    16: begin
                        // long run to reach position saturation
                        add_item(ACT_CLEAR, 0, 0, 0, 0);
                        n = $urandom_range(34, 40);
                        for (int i = 0; i < n; i++)
                            add_item(ACT_FEED, ($urandom_range(0, 1) == 0) ? 0
                                               : $urandom_range(0, 255), 0, 0, 0);
                    end
                    default: begin
                        a = t_action'($urandom_range(0, 3));
                        idx = $urandom_range(0, NUM_KW - 1);
                        l = $urandom_range(0, 32);
                        if (a == ACT_WR_LEN) begin
                            n = 0;
                            while (n < KW_MAX && gen_wr[idx][n]) n++;
                            l = $urandom_range(0, n);
                            if (n == KW_MAX && $urandom_range(0, 3) == 0)
                                l = $urandom_range(33, 63);
                        end
                        add_item(a, $urandom_range(0, 255), idx, $urandom_range(0, 31), l);
                    end
                endcase
            end
        end

        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
